// File: sv/best_fit_block_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit block allocator
// Shared property forms on the clk/rst_n of the including scope.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define BFA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Types, codes and command/status structs of the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int ADDR_W    = 32;
    localparam int ALIGN_W   = 13;
    localparam int PAD_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_W     = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_DEF_ALIGN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT = 3'd3;

    localparam logic [ALIGN_W-1:0] DEF_ALIGN_RST   = 13'd16;
    localparam logic [ADDR_W-1:0]  REGION_SIZE_RST = 32'd1048576;
    localparam logic [ADDR_W-1:0]  SMALL_LIMIT_RST = 32'd256;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_SMALL   = 3'd2,
        ST_OUTSIDE = 3'd3,
        ST_FULL    = 3'd4,
        ST_UNKNOWN = 3'd5
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] len;
        logic [PAD_W-1:0]  pad;
        logic              taken;
    } entry_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SCAN, OP_DIV1, OP_PAD1, OP_DIV2, OP_PAD2, OP_FIT,
        OP_INS_INIT, OP_SH_RD, OP_SH_WR, OP_WR_NEW, OP_WR_BEST, OP_FREE_HIT,
        OP_RD_NEXT, OP_EV_NEXT, OP_RD_PREV, OP_EV_PREV, OP_RMN_INIT, OP_RMC_INIT,
        OP_WR_PREV, OP_WR_CUR, OP_DEC, OP_RES, OP_PUSH
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic func;
        logic host_req;
        logic outside;
        logic scan_done;
        logic found;
        logic div_busy;
        logic p_low;
        logic fits;
        logic split;
        logic full;
        logic merge_n;
        logic merge_p;
        logic sh_done;
        logic out_free;
    } sts_t;

endpackage

// File: sv/bfa_if.sv
// ----------------------------------------------------------------------------
// bfa_if
// Valid/ready channels: request, response and configuration write.
// ----------------------------------------------------------------------------
interface bfa_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] req_size;
    logic [12:0] req_alignment;
    logic [31:0] free_addr;

    modport source (output valid, func, req_size, req_alignment, free_addr, input ready);
    modport sink   (input valid, func, req_size, req_alignment, free_addr, output ready);
endinterface

interface bfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_addr;
    logic [2:0]  status;
    logic [31:0] used_bytes;
    logic [31:0] peak_bytes;

    modport source (output valid, result_addr, status, used_bytes, peak_bytes, input ready);
    modport sink   (input valid, result_addr, status, used_bytes, peak_bytes, output ready);
endinterface

interface bfa_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/bfa_div.sv
// ----------------------------------------------------------------------------
// bfa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfa_div import bfa_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_W-1:0]   dividend,
    input  logic [ALIGN_W-1:0] divisor,
    output logic               busy,
    output logic [DIV_W-1:0]   quo,
    output logic [ALIGN_W-1:0] rem
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic [DIV_W-1:0]   q_reg;
    logic [ALIGN_W-1:0] r_reg;
    logic [ALIGN_W-1:0] d_reg;
    logic [ALIGN_W:0]   r_sh;
    logic               ge;

    assign r_sh = {r_reg, q_reg[DIV_W-1]};
    assign ge   = r_sh >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DIV_W-2:0], ge};
            r_reg <= ge ? ALIGN_W'(r_sh - {1'b0, d_reg}) : r_sh[ALIGN_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;
    assign rem  = r_reg;

endmodule

// File: sv/bfa_dp.sv
// ----------------------------------------------------------------------------
// bfa_dp
// Datapath: block table, scan, padding arithmetic, shifts and counters.
// ----------------------------------------------------------------------------
module bfa_dp import bfa_pkg::*; #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 in_func,
    input  logic [ADDR_W-1:0]    in_size,
    input  logic [ALIGN_W-1:0]   in_align,
    input  logic [ADDR_W-1:0]    in_faddr,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [ADDR_W-1:0]    out_addr,
    output logic [2:0]           out_status,
    output logic [ADDR_W-1:0]    out_used,
    output logic [ADDR_W-1:0]    out_peak
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [33:0]      HDR34 = 34'(HEADER_BYTES);
    localparam logic [PAD_W-1:0] HDR16 = PAD_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] MAXC  = CNT_W'(MAX_BLOCKS);

    logic [ALIGN_W-1:0] def_align_reg;
    logic [ADDR_W-1:0]  rsize_reg, rbase_reg, small_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [ADDR_W-1:0]  used_reg, peak_reg;
    logic               fresh_reg, rd0_reg;

    logic               func_reg;
    logic [ADDR_W-1:0]  size_reg, faddr_reg;
    logic [ALIGN_W-1:0] a_reg;

    logic [CNT_W-1:0]   i_reg;
    logic               pv_reg, found_reg;
    logic [IDX_W-1:0]   pidx_reg, best_reg;
    logic [ADDR_W-1:0]  bstart_reg, blen_reg;

    logic [PAD_W-1:0]   p_reg, pad_reg;
    logic [33:0]        needed_reg;
    logic               fit_reg, split_reg, merge_n_reg, merge_p_reg;
    entry_t             prv_reg;

    logic [CNT_W-1:0]   dst_reg, lim_reg;
    logic               up_reg;

    logic [ADDR_W-1:0]  res_addr_reg;
    status_t            res_st_reg;
    logic               ov_reg;
    logic [ADDR_W-1:0]  oaddr_reg, oused_reg, opeak_reg;
    status_t            ost_reg;

    logic                       we;
    logic [IDX_W-1:0]           waddr, raddr;
    entry_t                     wdata;
    logic [$bits(entry_t)-1:0]  ram_rdata;
    entry_t                     rd_e;

    logic [ALIGN_W-1:0] a_sel, a_eff;
    logic [33:0]        want, dsum, needed_c;
    logic [32:0]        base_end, abs_a;
    logic               hit_a, hit_f, hit, has_next;
    logic [IDX_W-1:0]   best_p1, best_m1;
    logic [CNT_W-1:0]   dst_m1, dst_p1;
    logic [PAD_W-1:0]   pad_c, p1_c;
    logic [ADDR_W-1:0]  rest_c, alloc_c, used_add;
    logic [DIV_W-1:0]   div_in, div_quo;
    logic [ALIGN_W-1:0] div_rem;
    logic               div_busy, div_start;

    bfa_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_BLOCKS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    bfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in),
        .divisor  (a_reg),
        .busy     (div_busy),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    always_comb
    begin
        rd_e = entry_t'(ram_rdata);
        if (rd0_reg && fresh_reg)
        begin
            rd_e = '{start: '0, len: rsize_reg, pad: '0, taken: 1'b0};
        end
    end

    assign a_sel    = (in_align != '0) ? in_align : def_align_reg;
    assign a_eff    = (a_sel == '0) ? ALIGN_W'(1) : a_sel;
    assign want     = {2'b0, size_reg} + HDR34 + 34'(a_reg);
    assign base_end = {1'b0, rbase_reg} + {1'b0, rsize_reg};
    assign dsum     = {2'b0, rbase_reg} + {2'b0, rd_e.start} + 34'(rd_e.pad) + HDR34;
    assign hit_a    = !rd_e.taken && ({2'b0, rd_e.len} >= want)
                      && (!found_reg || rd_e.len < blen_reg);
    assign hit_f    = rd_e.taken && (dsum == {2'b0, faddr_reg}) && !found_reg;
    assign hit      = pv_reg && (func_reg ? hit_f : hit_a);
    assign abs_a    = {1'b0, rbase_reg} + {1'b0, bstart_reg};
    assign best_p1  = best_reg + 1'b1;
    assign best_m1  = best_reg - 1'b1;
    assign dst_m1   = dst_reg - 1'b1;
    assign dst_p1   = dst_reg + 1'b1;
    assign has_next = (CNT_W'(best_reg) + 1'b1) < count_reg;
    assign pad_c    = p_reg - HDR16;
    assign needed_c = {2'b0, size_reg} + 34'(pad_c) + HDR34;
    assign rest_c   = blen_reg - needed_reg[ADDR_W-1:0];
    assign alloc_c  = split_reg ? needed_reg[ADDR_W-1:0] : blen_reg;
    assign used_add = used_reg + alloc_c;
    assign p1_c     = (div_rem == '0) ? PAD_W'(a_reg) : PAD_W'(a_reg) - PAD_W'(div_rem);

    assign div_start = (cmd.op == OP_DIV1) || (cmd.op == OP_DIV2);
    assign div_in    = (cmd.op == OP_DIV1) ? abs_a
                     : DIV_W'(HDR16 - p_reg + PAD_W'(a_reg) - 1'b1);

    always_comb
    begin
        raddr = '0;
        we    = 1'b0;
        waddr = '0;
        wdata = rd_e;
        case (cmd.op)
            OP_SCAN:    raddr = i_reg[IDX_W-1:0];
            OP_SH_RD:   raddr = up_reg ? dst_m1[IDX_W-1:0] : dst_p1[IDX_W-1:0];
            OP_RD_NEXT: raddr = best_p1;
            OP_RD_PREV: raddr = best_m1;
            OP_SH_WR:
            begin
                we    = 1'b1;
                waddr = dst_reg[IDX_W-1:0];
            end
            OP_WR_NEW:
            begin
                we    = 1'b1;
                waddr = best_p1;
                wdata = '{start: bstart_reg + needed_reg[ADDR_W-1:0], len: rest_c,
                          pad: '0, taken: 1'b0};
            end
            OP_WR_BEST:
            begin
                we    = 1'b1;
                waddr = best_reg;
                wdata = '{start: bstart_reg, len: alloc_c, pad: pad_reg, taken: 1'b1};
            end
            OP_WR_PREV:
            begin
                we    = 1'b1;
                waddr = best_m1;
                wdata = '{start: prv_reg.start, len: prv_reg.len + blen_reg,
                          pad: prv_reg.pad, taken: prv_reg.taken};
            end
            OP_WR_CUR:
            begin
                we    = 1'b1;
                waddr = best_reg;
                wdata = '{start: bstart_reg, len: blen_reg, pad: '0, taken: 1'b0};
            end
            default:
            begin
                raddr = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_align_reg <= DEF_ALIGN_RST;
            rsize_reg     <= REGION_SIZE_RST;
            rbase_reg     <= '0;
            small_reg     <= SMALL_LIMIT_RST;
            count_reg     <= CNT_W'(1);
            used_reg      <= '0;
            peak_reg      <= '0;
            fresh_reg     <= 1'b1;
            rd0_reg       <= 1'b0;
            i_reg         <= '0;
            pv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            rd0_reg <= (raddr == '0);
            if (we && waddr == '0)
            begin
                fresh_reg <= 1'b0;
            end
            ov_reg <= (cmd.op == OP_PUSH) || (ov_reg && !out_ready);
            case (cmd.op)
                OP_LOAD:
                begin
                    i_reg     <= '0;
                    pv_reg    <= 1'b0;
                    found_reg <= 1'b0;
                end
                OP_SCAN:
                begin
                    if (hit)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (i_reg < count_reg && !(func_reg && (found_reg || hit)))
                    begin
                        pv_reg <= 1'b1;
                        i_reg  <= i_reg + 1'b1;
                    end
                    else
                    begin
                        pv_reg <= 1'b0;
                    end
                end
                OP_WR_NEW:   count_reg <= count_reg + 1'b1;
                OP_DEC:      count_reg <= count_reg - 1'b1;
                OP_WR_BEST:
                begin
                    used_reg <= used_add;
                    if (used_add > peak_reg)
                    begin
                        peak_reg <= used_add;
                    end
                end
                OP_FREE_HIT: used_reg <= used_reg - blen_reg;
                default:     ;
            endcase
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_DEF_ALIGN:   def_align_reg <= cfg_data[ALIGN_W-1:0];
                    CFG_REGION_SIZE:
                    begin
                        rsize_reg <= cfg_data;
                        fresh_reg <= 1'b1;
                        count_reg <= CNT_W'(1);
                        used_reg  <= '0;
                        peak_reg  <= '0;
                    end
                    CFG_REGION_BASE: rbase_reg <= cfg_data;
                    CFG_SMALL_LIMIT: small_reg <= cfg_data;
                    default:         rbase_reg <= rbase_reg;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                func_reg  <= in_func;
                size_reg  <= in_size;
                a_reg     <= a_eff;
                faddr_reg <= in_faddr;
            end
            OP_SCAN:
            begin
                if (i_reg < count_reg)
                begin
                    pidx_reg <= i_reg[IDX_W-1:0];
                end
                if (hit)
                begin
                    best_reg   <= pidx_reg;
                    bstart_reg <= rd_e.start;
                    blen_reg   <= rd_e.len;
                end
            end
            OP_PAD1: p_reg <= p1_c;
            OP_PAD2: p_reg <= p_reg + PAD_W'(a_reg * div_quo[8:0]);
            OP_FIT:
            begin
                pad_reg    <= pad_c;
                needed_reg <= needed_c;
                fit_reg    <= {2'b0, blen_reg} >= needed_c;
                split_reg  <= (blen_reg - needed_c[ADDR_W-1:0]) > ADDR_W'(HEADER_BYTES);
            end
            OP_INS_INIT:
            begin
                dst_reg <= count_reg;
                lim_reg <= CNT_W'(best_reg) + 1'b1;
                up_reg  <= 1'b1;
            end
            OP_RMN_INIT:
            begin
                dst_reg <= CNT_W'(best_reg) + 1'b1;
                lim_reg <= count_reg - 1'b1;
                up_reg  <= 1'b0;
            end
            OP_RMC_INIT:
            begin
                dst_reg <= CNT_W'(best_reg);
                lim_reg <= count_reg - 1'b1;
                up_reg  <= 1'b0;
            end
            OP_SH_WR:    dst_reg <= up_reg ? dst_m1 : dst_p1;
            OP_WR_BEST:  res_addr_reg <= abs_a[ADDR_W-1:0] + ADDR_W'(pad_reg)
                                         + ADDR_W'(HEADER_BYTES);
            OP_EV_NEXT:
            begin
                merge_n_reg <= has_next && !rd_e.taken;
                if (has_next && !rd_e.taken)
                begin
                    blen_reg <= blen_reg + rd_e.len;
                end
            end
            OP_EV_PREV:
            begin
                merge_p_reg <= (best_reg != '0) && !rd_e.taken;
                prv_reg     <= rd_e;
            end
            OP_RES:
            begin
                res_st_reg <= cmd.code;
                if (cmd.code != ST_OK || func_reg)
                begin
                    res_addr_reg <= '0;
                end
            end
            OP_PUSH:
            begin
                oaddr_reg <= res_addr_reg;
                ost_reg   <= res_st_reg;
                oused_reg <= used_reg;
                opeak_reg <= peak_reg;
            end
            default:
            begin
                up_reg <= up_reg;
            end
        endcase
    end

    always_comb
    begin
        sts.func      = func_reg;
        sts.host_req  = size_reg <= small_reg;
        sts.outside   = (faddr_reg < rbase_reg) || ({1'b0, faddr_reg} >= base_end);
        sts.scan_done = (func_reg && found_reg) || (!pv_reg && i_reg >= count_reg);
        sts.found     = found_reg;
        sts.div_busy  = div_busy;
        sts.p_low     = p_reg < HDR16;
        sts.fits      = fit_reg;
        sts.split     = split_reg;
        sts.full      = count_reg >= MAXC;
        sts.merge_n   = merge_n_reg;
        sts.merge_p   = merge_p_reg;
        sts.sh_done   = dst_reg == lim_reg;
        sts.out_free  = !ov_reg || out_ready;
    end

    assign out_valid  = ov_reg;
    assign out_addr   = oaddr_reg;
    assign out_status = 3'(ost_reg);
    assign out_used   = oused_reg;
    assign out_peak   = opeak_reg;

endmodule

// File: sv/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer for allocate and free requests.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [23:0] {
        S_IDLE  = 24'h000001, S_CHK  = 24'h000002, S_SCAN = 24'h000004,
        S_SDEC  = 24'h000008, S_DIV1 = 24'h000010, S_PADC = 24'h000020,
        S_DIV2  = 24'h000040, S_FIT  = 24'h000080, S_FDEC = 24'h000100,
        S_SHR   = 24'h000200, S_SHW  = 24'h000400, S_WNEW = 24'h000800,
        S_WBEST = 24'h001000, S_FRN  = 24'h002000, S_FEN  = 24'h004000,
        S_FRP   = 24'h008000, S_FEP  = 24'h010000, S_FM   = 24'h020000,
        S_DECN  = 24'h040000, S_FP   = 24'h080000, S_RMC  = 24'h100000,
        S_DECC  = 24'h200000, S_OK   = 24'h400000, S_OUT  = 24'h800000
    } state_t;

    typedef enum logic [1:0] {PH_INS, PH_RMN, PH_RMC} phase_t;

    state_t state_reg, state_next;
    phase_t ph_reg, ph_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= PH_INS;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        cmd.op     = OP_NONE;
        cmd.code   = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.func ? sts.outside : sts.host_req)
                begin
                    cmd.op     = OP_RES;
                    cmd.code   = sts.func ? ST_OUTSIDE : ST_SMALL;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_SDEC;
                end
                else
                begin
                    cmd.op = OP_SCAN;
                end
            end
            S_SDEC:
            begin
                if (!sts.found)
                begin
                    cmd.op     = OP_RES;
                    cmd.code   = sts.func ? ST_UNKNOWN : ST_NOFIT;
                    state_next = S_OUT;
                end
                else if (sts.func)
                begin
                    cmd.op     = OP_FREE_HIT;
                    state_next = S_FRN;
                end
                else
                begin
                    cmd.op     = OP_DIV1;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (!sts.div_busy)
                begin
                    cmd.op     = OP_PAD1;
                    state_next = S_PADC;
                end
            end
            S_PADC:
            begin
                if (sts.p_low)
                begin
                    cmd.op     = OP_DIV2;
                    state_next = S_DIV2;
                end
                else
                begin
                    state_next = S_FIT;
                end
            end
            S_DIV2:
            begin
                if (!sts.div_busy)
                begin
                    cmd.op     = OP_PAD2;
                    state_next = S_FIT;
                end
            end
            S_FIT:
            begin
                cmd.op     = OP_FIT;
                state_next = S_FDEC;
            end
            S_FDEC:
            begin
                if (!sts.fits)
                begin
                    cmd.op     = OP_RES;
                    cmd.code   = ST_NOFIT;
                    state_next = S_OUT;
                end
                else if (sts.split && sts.full)
                begin
                    cmd.op     = OP_RES;
                    cmd.code   = ST_FULL;
                    state_next = S_OUT;
                end
                else if (sts.split)
                begin
                    cmd.op     = OP_INS_INIT;
                    ph_next    = PH_INS;
                    state_next = S_SHR;
                end
                else
                begin
                    cmd.op     = OP_WR_BEST;
                    state_next = S_OK;
                end
            end
            S_SHR:
            begin
                if (sts.sh_done)
                begin
                    unique case (ph_reg)
                        PH_INS:  state_next = S_WNEW;
                        PH_RMN:  state_next = S_DECN;
                        PH_RMC:  state_next = S_DECC;
                        default: state_next = S_IDLE;
                    endcase
                end
                else
                begin
                    cmd.op     = OP_SH_RD;
                    state_next = S_SHW;
                end
            end
            S_SHW:
            begin
                cmd.op     = OP_SH_WR;
                state_next = S_SHR;
            end
            S_WNEW:
            begin
                cmd.op     = OP_WR_NEW;
                state_next = S_WBEST;
            end
            S_WBEST:
            begin
                cmd.op     = OP_WR_BEST;
                state_next = S_OK;
            end
            S_FRN:
            begin
                cmd.op     = OP_RD_NEXT;
                state_next = S_FEN;
            end
            S_FEN:
            begin
                cmd.op     = OP_EV_NEXT;
                state_next = S_FRP;
            end
            S_FRP:
            begin
                cmd.op     = OP_RD_PREV;
                state_next = S_FEP;
            end
            S_FEP:
            begin
                cmd.op     = OP_EV_PREV;
                state_next = S_FM;
            end
            S_FM:
            begin
                if (sts.merge_n)
                begin
                    cmd.op     = OP_RMN_INIT;
                    ph_next    = PH_RMN;
                    state_next = S_SHR;
                end
                else
                begin
                    state_next = S_FP;
                end
            end
            S_DECN:
            begin
                cmd.op     = OP_DEC;
                state_next = S_FP;
            end
            S_FP:
            begin
                if (sts.merge_p)
                begin
                    cmd.op     = OP_WR_PREV;
                    state_next = S_RMC;
                end
                else
                begin
                    cmd.op     = OP_WR_CUR;
                    state_next = S_OK;
                end
            end
            S_RMC:
            begin
                cmd.op     = OP_RMC_INIT;
                ph_next    = PH_RMC;
                state_next = S_SHR;
            end
            S_DECC:
            begin
                cmd.op     = OP_DEC;
                state_next = S_OK;
            end
            S_OK:
            begin
                cmd.op     = OP_RES;
                cmd.code   = ST_OK;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_PUSH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// File: sv/best_fit_block_allocator_top.sv
// A small or outside request is answered from the check state, with no scan.
// Allocate: a scan of the block table, one or two divisions and a read and a
// write per entry moved on a split.
// Free: scan up to the block, then a read and a write per entry moved on a merge.
// One request at a time; the next beat is taken while a response waits.
// Reset (async, rst_n low) restores the configuration and control registers and one free block.
// ----------------------------------------------------------------------------
// best_fit_block_allocator_top
// Best-fit region allocator with coalescing on free.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_top import bfa_pkg::*; #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32
) (
    input logic      clk,
    input logic      rst_n,
    bfa_req_if.sink  req,
    bfa_rsp_if.source rsp,
    bfa_cfg_if.sink  cfg
);

    cmd_t cmd;
    sts_t sts;

    assign cfg.ready = 1'b1;

    bfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfa_dp #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_func    (req.func),
        .in_size    (req.req_size),
        .in_align   (req.req_alignment),
        .in_faddr   (req.free_addr),
        .cfg_we     (cfg.valid),
        .cfg_idx    (cfg.index),
        .cfg_data   (cfg.data),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_addr   (rsp.result_addr),
        .out_status (rsp.status),
        .out_used   (rsp.used_bytes),
        .out_peak   (rsp.peak_bytes)
    );

endmodule

// File: sv/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_port_checks
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "best_fit_block_allocator_top_defines.svh"

module bfa_port_checks import bfa_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_result_addr,
    input logic [2:0]  rsp_status
);

    logic err_rsp;
    logic rsp_wait;

    assign err_rsp  = rsp_valid && rsp_status != 3'(ST_OK);
    assign rsp_wait = rsp_valid && !rsp_ready;

    // one request in flight: busy right after a beat is taken
    `BFA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready after beat")

    `BFA_ASSERT_IMPLY(a_addr_zero, err_rsp, rsp_result_addr == '0, "nonzero addr on error")

    `BFA_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_status), "response dropped")

    `BFA_ASSERT_NEXT(a_addr_hold, rsp_wait, $stable(rsp_result_addr), "response addr changed")

endmodule

bind best_fit_block_allocator_top bfa_port_checks u_bfa_port_checks (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_result_addr (rsp.result_addr),
    .rsp_status      (rsp.status)
);
